@@ rtl/moment_tensor_azimuth_rotation_defines.svh @@
// assertion macros shared by the tensor rotation rtl
`ifndef MOMENT_TENSOR_AZIMUTH_ROTATION_DEFINES_SVH
`define MOMENT_TENSOR_AZIMUTH_ROTATION_DEFINES_SVH
`ifndef SYNTHESIS
`define MTAR_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);
`define MTAR_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MTAR_ASSERT_IMP(label, ck, rn, ante, cons, msg)
`define MTAR_ASSERT_NXT(label, ck, rn, ante, cons, msg)
`endif
`endif

@@ rtl/mtar_pkg.sv @@
// types, constants and helper functions for the tensor rotation pipeline
package mtar_pkg;

	localparam int COMP_W       = 24;
	localparam int ANGLE_W      = 16;
	localparam int SINE_DEPTH   = 1024;
	localparam int SINE_IDX_W   = $clog2(SINE_DEPTH + 1);
	localparam int SINE_MAG_W   = 15;
	localparam int COEF_W       = SINE_MAG_W + 1;
	localparam int FRAC_W       = 15;
	localparam int IDX_SHIFT    = ANGLE_W - 2 - $clog2(SINE_DEPTH);
	localparam int WIDE_W       = COMP_W + 1;
	localparam int PROD_W       = COMP_W + 1;
	localparam int SUM_W        = PROD_W + 2;
	localparam int MULT_W       = WIDE_W + COEF_W;
	localparam int TAYLOR_TERMS = 12;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam logic [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(1) << (ANGLE_W - 2);

	typedef logic [SINE_MAG_W-1:0] sine_rom_t [0:SINE_DEPTH];

	typedef struct packed {
		logic [SINE_IDX_W-1:0] idx;
		logic                  neg;
	} sine_addr_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] rr;
		logic signed [COMP_W-1:0] tt;
		logic signed [COMP_W-1:0] pp;
		logic signed [COMP_W-1:0] rt;
		logic signed [COMP_W-1:0] rp;
		logic signed [COMP_W-1:0] tp;
	} tensor_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] si;
		logic signed [COEF_W-1:0] co;
		logic signed [COEF_W-1:0] s2;
		logic signed [COEF_W-1:0] c2;
		logic signed [COEF_W-1:0] cc;
		logic signed [COEF_W-1:0] ss;
	} coef_t;

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic v_s4;
	} pipe_ctl_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] val;
		logic                     clip;
	} sat_t;

	// shift-subtract long division for the table build
	function automatic longint unsigned const_udiv(
		input longint unsigned num,
		input longint unsigned den
	);
		longint unsigned q;
		longint unsigned r;
		int              i;
		q = 0;
		r = 0;
		for (i = 63; i >= 0; i--) begin
			r = (r << 1) | 64'(num[i]);
			if (r >= den) begin
				r = r - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// quarter-wave sine in q0.15, taylor series in q30, evaluated at elaboration
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t         rom;
		longint unsigned   x;
		longint unsigned   t;
		longint unsigned   pos;
		longint unsigned   neg;
		longint unsigned   s;
		longint unsigned   e;
		longint unsigned   dv;
		int                k;
		int                n;
		for (k = 0; k <= SINE_DEPTH; k++) begin
			x = (HALF_PI_Q30 * longint'(k)) >> $clog2(SINE_DEPTH);
			t = x;
			pos = x;
			neg = 0;
			for (n = 1; n <= TAYLOR_TERMS; n++) begin
				t = (((t * x) >> 30) * x) >> 30;
				dv = longint'(2 * n) * longint'(2 * n + 1);
				t = const_udiv(t, dv);
				if (n[0]) neg = neg + t;
				else pos = pos + t;
			end
			s = (pos > neg) ? pos - neg : 0;
			e = (s + (64'd1 << 14)) >> 15;
			rom[k] = (e > 64'd32767) ? {SINE_MAG_W{1'b1}} : e[SINE_MAG_W-1:0];
		end
		return rom;
	endfunction

	// table address and sign for a binary angle
	function automatic sine_addr_t sine_addr(input logic [ANGLE_W-1:0] ang);
		logic [SINE_IDX_W-1:0] base;
		sine_addr_t            res;
		base = SINE_IDX_W'(ang[ANGLE_W-3:0] >> IDX_SHIFT);
		res.neg = ang[ANGLE_W-1];
		res.idx = ang[ANGLE_W-2] ? SINE_IDX_W'(SINE_DEPTH) - base : base;
		return res;
	endfunction

	// v * c / 2^15 (or 2^16), rounded half up
	function automatic logic signed [PROD_W-1:0] mul_round(
		input logic signed [WIDE_W-1:0] v,
		input logic signed [COEF_W-1:0] c,
		input logic                     half
	);
		logic signed [MULT_W-1:0] p;
		logic signed [MULT_W-1:0] r;
		logic signed [MULT_W-1:0] q;
		p = v * c;
		if (half) begin
			r = p + (MULT_W'(1) << FRAC_W);
			q = r >>> (FRAC_W + 1);
		end else begin
			r = p + (MULT_W'(1) << (FRAC_W - 1));
			q = r >>> FRAC_W;
		end
		return q[PROD_W-1:0];
	endfunction

	function automatic sat_t saturate(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		sat_t                    res;
		hi = SUM_W'((64'sd1 <<< (COMP_W - 1)) - 64'sd1);
		lo = ~hi;
		if (v > hi) begin
			res.val = hi[COMP_W-1:0];
			res.clip = 1'b1;
		end else if (v < lo) begin
			res.val = lo[COMP_W-1:0];
			res.clip = 1'b1;
		end else begin
			res.val = v[COMP_W-1:0];
			res.clip = 1'b0;
		end
		return res;
	endfunction

endpackage

@@ rtl/mtar_sine_rom.sv @@
// quarter-wave sine rom with two registered read ports
module mtar_sine_rom (
	input  logic                                clk,
	input  logic                                rd_en,
	input  logic [mtar_pkg::SINE_IDX_W-1:0]     addr_a,
	input  logic [mtar_pkg::SINE_IDX_W-1:0]     addr_b,
	output logic [mtar_pkg::SINE_MAG_W-1:0]     data_a,
	output logic [mtar_pkg::SINE_MAG_W-1:0]     data_b
);

	localparam mtar_pkg::sine_rom_t ROM = mtar_pkg::build_sine_rom();

	logic [mtar_pkg::SINE_MAG_W-1:0] data_a_q;
	logic [mtar_pkg::SINE_MAG_W-1:0] data_b_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_a_q <= ROM[addr_a];
			data_b_q <= ROM[addr_b];
		end
	end

	assign data_a = data_a_q;
	assign data_b = data_b_q;

endmodule

@@ rtl/mtar_coef.sv @@
// stages 1 and 2: sine lookups, signed coefficients, squares and tt - pp
module mtar_coef (
	input  logic                               clk,
	input  mtar_pkg::pipe_ctl_t                ctl,
	input  logic [mtar_pkg::ANGLE_W-1:0]       azimuth,
	input  mtar_pkg::tensor_t                  tensor_in,
	output mtar_pkg::coef_t                    coef,
	output mtar_pkg::tensor_t                  tensor,
	output logic signed [mtar_pkg::WIDE_W-1:0] diff
);

	logic [mtar_pkg::ANGLE_W-1:0] ang_co;
	logic [mtar_pkg::ANGLE_W-1:0] ang_s2;
	logic [mtar_pkg::ANGLE_W-1:0] ang_c2;
	mtar_pkg::sine_addr_t         a_si;
	mtar_pkg::sine_addr_t         a_co;
	mtar_pkg::sine_addr_t         a_s2;
	mtar_pkg::sine_addr_t         a_c2;

	logic [mtar_pkg::SINE_MAG_W-1:0] m_si;
	logic [mtar_pkg::SINE_MAG_W-1:0] m_co;
	logic [mtar_pkg::SINE_MAG_W-1:0] m_s2;
	logic [mtar_pkg::SINE_MAG_W-1:0] m_c2;
	logic [3:0]                      neg_s1;
	mtar_pkg::tensor_t               tensor_s1;

	logic signed [mtar_pkg::COEF_W-1:0]   si_v;
	logic signed [mtar_pkg::COEF_W-1:0]   co_v;
	logic signed [mtar_pkg::COEF_W-1:0]   s2_v;
	logic signed [mtar_pkg::COEF_W-1:0]   c2_v;
	logic signed [2*mtar_pkg::COEF_W-1:0] sq_co;
	logic signed [2*mtar_pkg::COEF_W-1:0] sq_si;
	logic signed [2*mtar_pkg::COEF_W-1:0] rnd_co;
	logic signed [2*mtar_pkg::COEF_W-1:0] rnd_si;

	mtar_pkg::coef_t                     coef_s2;
	mtar_pkg::tensor_t                   tensor_s2;
	logic signed [mtar_pkg::WIDE_W-1:0]  diff_s2;

	// cosine is sine a quarter turn later; doubled angle wraps
	assign ang_co = azimuth + mtar_pkg::QUARTER_TURN;
	assign ang_s2 = {azimuth[mtar_pkg::ANGLE_W-2:0], 1'b0};
	assign ang_c2 = ang_s2 + mtar_pkg::QUARTER_TURN;
	assign a_si   = mtar_pkg::sine_addr(azimuth);
	assign a_co   = mtar_pkg::sine_addr(ang_co);
	assign a_s2   = mtar_pkg::sine_addr(ang_s2);
	assign a_c2   = mtar_pkg::sine_addr(ang_c2);

	mtar_sine_rom u_rom_single (
		.clk    (clk),
		.rd_en  (ctl.ld_s1),
		.addr_a (a_si.idx),
		.addr_b (a_co.idx),
		.data_a (m_si),
		.data_b (m_co)
	);

	mtar_sine_rom u_rom_double (
		.clk    (clk),
		.rd_en  (ctl.ld_s1),
		.addr_a (a_s2.idx),
		.addr_b (a_c2.idx),
		.data_a (m_s2),
		.data_b (m_c2)
	);

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			neg_s1    <= {a_c2.neg, a_s2.neg, a_co.neg, a_si.neg};
			tensor_s1 <= tensor_in;
		end
	end

	always_comb begin
		si_v = neg_s1[0] ? -$signed({1'b0, m_si}) : $signed({1'b0, m_si});
		co_v = neg_s1[1] ? -$signed({1'b0, m_co}) : $signed({1'b0, m_co});
		s2_v = neg_s1[2] ? -$signed({1'b0, m_s2}) : $signed({1'b0, m_s2});
		c2_v = neg_s1[3] ? -$signed({1'b0, m_c2}) : $signed({1'b0, m_c2});
		sq_co = co_v * co_v;
		sq_si = si_v * si_v;
		rnd_co = (sq_co + (2*mtar_pkg::COEF_W)'(1 << (mtar_pkg::FRAC_W - 1)))
			>>> mtar_pkg::FRAC_W;
		rnd_si = (sq_si + (2*mtar_pkg::COEF_W)'(1 << (mtar_pkg::FRAC_W - 1)))
			>>> mtar_pkg::FRAC_W;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			coef_s2.si <= si_v;
			coef_s2.co <= co_v;
			coef_s2.s2 <= s2_v;
			coef_s2.c2 <= c2_v;
			coef_s2.cc <= rnd_co[mtar_pkg::COEF_W-1:0];
			coef_s2.ss <= rnd_si[mtar_pkg::COEF_W-1:0];
			tensor_s2  <= tensor_s1;
			// full width, never clipped
			diff_s2    <= mtar_pkg::WIDE_W'(tensor_s1.tt) - mtar_pkg::WIDE_W'(tensor_s1.pp);
		end
	end

	assign coef   = coef_s2;
	assign tensor = tensor_s2;
	assign diff   = diff_s2;

endmodule

@@ rtl/mtar_mix.sv @@
// stages 3 and 4: rounded products, sums and saturation
`include "moment_tensor_azimuth_rotation_defines.svh"
module mtar_mix (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mtar_pkg::pipe_ctl_t                ctl,
	input  mtar_pkg::coef_t                    coef,
	input  mtar_pkg::tensor_t                  tensor,
	input  logic signed [mtar_pkg::WIDE_W-1:0] diff,
	output mtar_pkg::tensor_t                  result,
	output logic                               saturated
);

	logic signed [mtar_pkg::WIDE_W-1:0] w_tt;
	logic signed [mtar_pkg::WIDE_W-1:0] w_pp;
	logic signed [mtar_pkg::WIDE_W-1:0] w_rt;
	logic signed [mtar_pkg::WIDE_W-1:0] w_rp;
	logic signed [mtar_pkg::WIDE_W-1:0] w_tp;
	logic signed [mtar_pkg::COEF_W-1:0] neg_s2;
	logic signed [mtar_pkg::COEF_W-1:0] neg_si;

	logic signed [mtar_pkg::PROD_W-1:0] tt_cc_s3;
	logic signed [mtar_pkg::PROD_W-1:0] pp_ss_s3;
	logic signed [mtar_pkg::PROD_W-1:0] tp_ns2_s3;
	logic signed [mtar_pkg::PROD_W-1:0] pp_cc_s3;
	logic signed [mtar_pkg::PROD_W-1:0] tt_ss_s3;
	logic signed [mtar_pkg::PROD_W-1:0] tp_s2_s3;
	logic signed [mtar_pkg::PROD_W-1:0] rt_co_s3;
	logic signed [mtar_pkg::PROD_W-1:0] rp_nsi_s3;
	logic signed [mtar_pkg::PROD_W-1:0] rt_si_s3;
	logic signed [mtar_pkg::PROD_W-1:0] rp_co_s3;
	logic signed [mtar_pkg::PROD_W-1:0] df_s2_s3;
	logic signed [mtar_pkg::PROD_W-1:0] tp_c2_s3;
	logic signed [mtar_pkg::COMP_W-1:0] rr_s3;

	logic signed [mtar_pkg::SUM_W-1:0] sum_tt;
	logic signed [mtar_pkg::SUM_W-1:0] sum_pp;
	logic signed [mtar_pkg::SUM_W-1:0] sum_rt;
	logic signed [mtar_pkg::SUM_W-1:0] sum_rp;
	logic signed [mtar_pkg::SUM_W-1:0] sum_tp;
	mtar_pkg::sat_t                    c_tt;
	mtar_pkg::sat_t                    c_pp;
	mtar_pkg::sat_t                    c_rt;
	mtar_pkg::sat_t                    c_rp;
	mtar_pkg::sat_t                    c_tp;

	mtar_pkg::tensor_t result_s4;
	logic              sat_s4;

	assign w_tt   = mtar_pkg::WIDE_W'(tensor.tt);
	assign w_pp   = mtar_pkg::WIDE_W'(tensor.pp);
	assign w_rt   = mtar_pkg::WIDE_W'(tensor.rt);
	assign w_rp   = mtar_pkg::WIDE_W'(tensor.rp);
	assign w_tp   = mtar_pkg::WIDE_W'(tensor.tp);
	// rounding is not symmetric, so the negated coefficient is multiplied itself
	assign neg_s2 = -coef.s2;
	assign neg_si = -coef.si;

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			tt_cc_s3  <= mtar_pkg::mul_round(w_tt, coef.cc, 1'b0);
			pp_ss_s3  <= mtar_pkg::mul_round(w_pp, coef.ss, 1'b0);
			tp_ns2_s3 <= mtar_pkg::mul_round(w_tp, neg_s2, 1'b0);
			pp_cc_s3  <= mtar_pkg::mul_round(w_pp, coef.cc, 1'b0);
			tt_ss_s3  <= mtar_pkg::mul_round(w_tt, coef.ss, 1'b0);
			tp_s2_s3  <= mtar_pkg::mul_round(w_tp, coef.s2, 1'b0);
			rt_co_s3  <= mtar_pkg::mul_round(w_rt, coef.co, 1'b0);
			rp_nsi_s3 <= mtar_pkg::mul_round(w_rp, neg_si, 1'b0);
			rt_si_s3  <= mtar_pkg::mul_round(w_rt, coef.si, 1'b0);
			rp_co_s3  <= mtar_pkg::mul_round(w_rp, coef.co, 1'b0);
			// half of sin 2a folded into the shift
			df_s2_s3  <= mtar_pkg::mul_round(diff, coef.s2, 1'b1);
			tp_c2_s3  <= mtar_pkg::mul_round(w_tp, coef.c2, 1'b0);
			rr_s3     <= tensor.rr;
		end
	end

	always_comb begin
		sum_tt = mtar_pkg::SUM_W'(tt_cc_s3) + mtar_pkg::SUM_W'(pp_ss_s3)
			+ mtar_pkg::SUM_W'(tp_ns2_s3);
		sum_pp = mtar_pkg::SUM_W'(pp_cc_s3) + mtar_pkg::SUM_W'(tt_ss_s3)
			+ mtar_pkg::SUM_W'(tp_s2_s3);
		sum_rt = mtar_pkg::SUM_W'(rt_co_s3) + mtar_pkg::SUM_W'(rp_nsi_s3);
		sum_rp = mtar_pkg::SUM_W'(rt_si_s3) + mtar_pkg::SUM_W'(rp_co_s3);
		sum_tp = mtar_pkg::SUM_W'(df_s2_s3) + mtar_pkg::SUM_W'(tp_c2_s3);
		c_tt = mtar_pkg::saturate(sum_tt);
		c_pp = mtar_pkg::saturate(sum_pp);
		c_rt = mtar_pkg::saturate(sum_rt);
		c_rp = mtar_pkg::saturate(sum_rp);
		c_tp = mtar_pkg::saturate(sum_tp);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			result_s4.rr <= rr_s3;
			result_s4.tt <= c_tt.val;
			result_s4.pp <= c_pp.val;
			result_s4.rt <= c_rt.val;
			result_s4.rp <= c_rp.val;
			result_s4.tp <= c_tp.val;
			sat_s4       <= c_tt.clip | c_pp.clip | c_rt.clip | c_rp.clip | c_tp.clip;
		end
	end

	assign result    = result_s4;
	assign saturated = sat_s4;

	// a raised flag means at least one rotated component sits on a rail
	`MTAR_ASSERT_IMP(a_sat_on_rail, clk, arst_n, ctl.v_s4 && sat_s4, (result_s4.tt == {1'b0, {(mtar_pkg::COMP_W-1){1'b1}}}) || (result_s4.tt == {1'b1, {(mtar_pkg::COMP_W-1){1'b0}}}) || (result_s4.pp == {1'b0, {(mtar_pkg::COMP_W-1){1'b1}}}) || (result_s4.pp == {1'b1, {(mtar_pkg::COMP_W-1){1'b0}}}) || (result_s4.rt == {1'b0, {(mtar_pkg::COMP_W-1){1'b1}}}) || (result_s4.rt == {1'b1, {(mtar_pkg::COMP_W-1){1'b0}}}) || (result_s4.rp == {1'b0, {(mtar_pkg::COMP_W-1){1'b1}}}) || (result_s4.rp == {1'b1, {(mtar_pkg::COMP_W-1){1'b0}}}) || (result_s4.tp == {1'b0, {(mtar_pkg::COMP_W-1){1'b1}}}) || (result_s4.tp == {1'b1, {(mtar_pkg::COMP_W-1){1'b0}}}), "saturated flag without a clipped component")

endmodule

@@ rtl/moment_tensor_azimuth_rotation.sv @@
// top level: four-stage tensor rotation pipeline with stream handshakes
// an accepted item passes the rom read, coefficient, product and sum stages in order before m_tvalid
// throughput: one item per cycle while m_tready is high; each stage holds one item and advances when the next frees
// a stalled output fills the stages behind it, bubbles are squeezed out on the way
// reset clears only the stage valid bits; the sine table is a constant rom, no clearing pass
`include "moment_tensor_azimuth_rotation_defines.svh"
module moment_tensor_azimuth_rotation (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [159:0] s_tdata,  // azimuth, rr_in, tt_in, pp_in, rt_in, rp_in, tp_in
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,  // rr_out, tt_out, pp_out, rt_out, rp_out, tp_out
	output logic         m_tuser   // saturated
);

	localparam int W = mtar_pkg::COMP_W;
	localparam int A = mtar_pkg::ANGLE_W;

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;
	logic rdy1;
	logic rdy2;
	logic rdy3;
	logic rdy4;

	mtar_pkg::pipe_ctl_t                ctl;
	mtar_pkg::tensor_t                  tensor_in;
	mtar_pkg::coef_t                    coef;
	mtar_pkg::tensor_t                  tensor_c;
	logic signed [mtar_pkg::WIDE_W-1:0] diff;
	mtar_pkg::tensor_t                  result;
	logic                               saturated;

	// a stage may load when it is empty or its item moves on
	assign rdy4 = !v_s4 || m_tready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign ctl.ld_s1 = rdy1 && s_tvalid;
	assign ctl.ld_s2 = rdy2 && v_s1;
	assign ctl.ld_s3 = rdy3 && v_s2;
	assign ctl.ld_s4 = rdy4 && v_s3;
	assign ctl.v_s4  = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	assign tensor_in.rr = s_tdata[A+W-1:A];
	assign tensor_in.tt = s_tdata[A+2*W-1:A+W];
	assign tensor_in.pp = s_tdata[A+3*W-1:A+2*W];
	assign tensor_in.rt = s_tdata[A+4*W-1:A+3*W];
	assign tensor_in.rp = s_tdata[A+5*W-1:A+4*W];
	assign tensor_in.tp = s_tdata[A+6*W-1:A+5*W];

	mtar_coef u_coef (
		.clk       (clk),
		.ctl       (ctl),
		.azimuth   (s_tdata[A-1:0]),
		.tensor_in (tensor_in),
		.coef      (coef),
		.tensor    (tensor_c),
		.diff      (diff)
	);

	mtar_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.coef      (coef),
		.tensor    (tensor_c),
		.diff      (diff),
		.result    (result),
		.saturated (saturated)
	);

	assign s_tready = rdy1;
	assign m_tvalid = v_s4;
	assign m_tdata  = {result.tp, result.rp, result.rt, result.pp, result.tt, result.rr};
	assign m_tuser  = saturated;

	// input only stalls when every stage holds an item
	`MTAR_ASSERT_IMP(a_stall_only_full, clk, arst_n, !s_tready, v_s1 && v_s2 && v_s3 && v_s4, "input stalled with a bubble in the pipeline")
	// an accepted item occupies stage one on the next cycle
	`MTAR_ASSERT_NXT(a_accept_fills_s1, clk, arst_n, s_tvalid && s_tready, v_s1, "accepted item missing from stage one")
	// a stage that cannot pass its item on keeps it
	`MTAR_ASSERT_NXT(a_s3_holds, clk, arst_n, v_s3 && !rdy4, v_s3 && v_s4, "stage three item lost during a stall")

endmodule
